/* hdl/length_prefixed_byte_ring_queue_macros.svh */
// ----------------------------------------------------------------------------
// length prefixed byte ring queue assertion macros
// shared concurrent assertion forms, sampled on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_BYTE_RING_QUEUE_MACROS_SVH
`define LENGTH_PREFIXED_BYTE_RING_QUEUE_MACROS_SVH

// same-cycle implication
`define LPBQ_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lpbq same-cycle check failed");

// next-cycle implication
`define LPBQ_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lpbq next-cycle check failed");

`endif

/* hdl/lpbq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpbq_pkg
// sizes, codes and controller/datapath interface types of the byte ring queue
// ----------------------------------------------------------------------------
package lpbq_pkg;

    // ring and message geometry
    localparam int RING_DEPTH    = 4096;
    localparam int MAX_MSG_LEN   = 64;
    localparam int HEADER_BYTES  = 4;
    localparam int RING_MIN      = 8;
    localparam int RING_SIZE_RST = (RING_DEPTH < 4096) ? RING_DEPTH : 4096;

    localparam int POS_W     = $clog2(RING_DEPTH);
    localparam int SIZE_W    = POS_W + 1;
    localparam int HDR_CNT_W = $clog2(HEADER_BYTES);

    // port field widths
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 1;
    localparam int ACT_W     = 2;
    localparam int LEN_IN_W  = 8;
    localparam int BYTE_W    = 8;
    localparam int ST_W      = 3;
    localparam int PLEN_W    = 6;
    localparam int FS_W      = 12;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RING_SIZE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUEUE_VALID = 1'd1;

    // action codes
    localparam logic [ACT_W-1:0] ACT_PUSH  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_POP   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;
    localparam logic [ACT_W-1:0] ACT_NOP   = 2'd3;

    // status codes
    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_FULL     = 3'd1;
    localparam logic [ST_W-1:0] ST_BAD_LEN  = 3'd2;
    localparam logic [ST_W-1:0] ST_EMPTY    = 3'd3;
    localparam logic [ST_W-1:0] ST_DISABLED = 3'd4;

    typedef logic [POS_W-1:0]  pos_t;
    typedef logic [SIZE_W-1:0] size_t;

    // controller to datapath commands
    typedef struct packed {
        logic            latch;
        logic            push_start;
        logic            drop_start;
        logic            hdr_wr;
        logic            dat_wr;
        logic            clear;
        logic            rd_head;
        logic            pop_hdr;
        logic            pop_end;
        logic            pop_rd;
        logic            emit;
        logic            emit_byte;
        logic [ST_W-1:0] status;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic             qvalid;
        logic [ACT_W-1:0] action;
        logic             start;
        logic             len_bad;
        logic             len_fits;
        logic             left_zero;
        logic             dropping;
        logic             empty;
        logic             hdr_last;
        logic             pop_zero;
        logic             pop_last;
        logic             out_free;
    } stat_t;

endpackage

/* hdl/lpbq_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpbq_ctrl
// sequencer for push, pop, clear and result transactions of the ring queue
// ----------------------------------------------------------------------------
module lpbq_ctrl import lpbq_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DECODE   = 4'd1;
    localparam logic [3:0] S_PUSH_HDR = 4'd2;
    localparam logic [3:0] S_PUSH_DAT = 4'd3;
    localparam logic [3:0] S_POP_HDR  = 4'd4;
    localparam logic [3:0] S_POP_END  = 4'd5;
    localparam logic [3:0] S_POP_RD   = 4'd6;
    localparam logic [3:0] S_POP_OUT  = 4'd7;
    localparam logic [3:0] S_EMIT     = 4'd8;

    logic [3:0]      state_reg, state_next;
    logic [ST_W-1:0] st_reg, st_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        st_next    = st_reg;
        cmd        = '0;
        cmd.status = st_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (!stat.qvalid)
                begin
                    st_next    = ST_DISABLED;
                    state_next = S_EMIT;
                end
                else
                begin
                    unique case (stat.action)
                        ACT_PUSH:
                        begin
                            if (stat.start)
                            begin
                                if (stat.len_bad)
                                begin
                                    cmd.drop_start = 1'b1;
                                    st_next        = ST_BAD_LEN;
                                    state_next     = S_EMIT;
                                end
                                else if (!stat.len_fits)
                                begin
                                    cmd.drop_start = 1'b1;
                                    st_next        = ST_FULL;
                                    state_next     = S_EMIT;
                                end
                                else
                                begin
                                    cmd.push_start = 1'b1;
                                    state_next     = S_PUSH_HDR;
                                end
                            end
                            else if (stat.left_zero)
                            begin
                                st_next    = stat.dropping ? ST_OK : ST_BAD_LEN;
                                state_next = S_EMIT;
                            end
                            else
                            begin
                                state_next = S_PUSH_DAT;
                            end
                        end
                        ACT_POP:
                        begin
                            if (stat.empty)
                            begin
                                st_next    = ST_EMPTY;
                                state_next = S_EMIT;
                            end
                            else
                            begin
                                cmd.rd_head = 1'b1;
                                state_next  = S_POP_HDR;
                            end
                        end
                        ACT_CLEAR:
                        begin
                            cmd.clear  = 1'b1;
                            st_next    = ST_OK;
                            state_next = S_EMIT;
                        end
                        default:
                        begin
                            st_next    = ST_OK;
                            state_next = S_EMIT;
                        end
                    endcase
                end
            end
            S_PUSH_HDR:
            begin
                cmd.hdr_wr = 1'b1;
                if (stat.hdr_last)
                begin
                    state_next = S_PUSH_DAT;
                end
            end
            S_PUSH_DAT:
            begin
                cmd.dat_wr = 1'b1;
                st_next    = ST_OK;
                state_next = S_EMIT;
            end
            S_POP_HDR:
            begin
                cmd.pop_hdr = 1'b1;
                state_next  = S_POP_END;
            end
            S_POP_END:
            begin
                cmd.pop_end = 1'b1;
                if (stat.pop_zero)
                begin
                    st_next    = ST_OK;
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_POP_RD;
                end
            end
            S_POP_RD:
            begin
                cmd.pop_rd = 1'b1;
                state_next = S_POP_OUT;
            end
            S_POP_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_byte = 1'b1;
                    cmd.status    = ST_OK;
                    state_next    = stat.pop_last ? S_IDLE : S_POP_RD;
                end
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            st_reg    <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            st_reg    <= st_next;
        end
    end

endmodule

/* hdl/lpbq_dp.sv */
`timescale 1ns / 1ps
`include "length_prefixed_byte_ring_queue_macros.svh"
// ----------------------------------------------------------------------------
// lpbq_dp
// ring memory, head/tail/write pointers, config registers and result register
// ----------------------------------------------------------------------------
module lpbq_dp import lpbq_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cmd_t                 cmd,
    output stat_t                stat,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic [ACT_W-1:0]     action,
    input  logic                 msg_start,
    input  logic [LEN_IN_W-1:0]  msg_length,
    input  logic [BYTE_W-1:0]    data_in,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [ST_W-1:0]      status,
    output logic [BYTE_W-1:0]    data_out,
    output logic [PLEN_W-1:0]    payload_length,
    output logic                 last_byte,
    output logic [FS_W-1:0]      free_space,
    output logic                 queue_empty
);

    // step one position around the ring
    function automatic pos_t adv1(input pos_t p, input size_t rs);
        size_t s;
        s = {1'b0, p} + SIZE_W'(1);
        return (s == rs) ? '0 : s[POS_W-1:0];
    endfunction

    // add an offset below the ring size and wrap once
    function automatic pos_t wrap_add(input pos_t p, input size_t n, input size_t rs);
        size_t s;
        s = {1'b0, p} + n;
        if (s >= rs)
        begin
            s = s - rs;
        end
        return s[POS_W-1:0];
    endfunction

    // ring storage
    logic [BYTE_W-1:0] ring_mem [RING_DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;
    logic              mem_we, mem_re;
    pos_t              mem_waddr, mem_raddr;
    logic [BYTE_W-1:0] mem_wdata;

    // latched input item
    logic [ACT_W-1:0]    act_reg;
    logic                start_reg;
    logic [LEN_IN_W-1:0] len_reg;
    logic [BYTE_W-1:0]   data_reg;

    // queue state
    size_t                ring_size_reg, ring_size_next;
    logic                 qvalid_reg, qvalid_next;
    pos_t                 head_reg, head_next;
    pos_t                 tail_reg, tail_next;
    pos_t                 wpos_reg, wpos_next;
    logic [PLEN_W-1:0]    left_reg, left_next;
    logic                 drop_reg, drop_next;
    logic [HDR_CNT_W-1:0] hdr_cnt_reg, hdr_cnt_next;
    pos_t                 rd_ptr_reg, rd_ptr_next;
    logic [PLEN_W-1:0]    pop_len_reg, pop_len_next;
    logic [PLEN_W-1:0]    pop_left_reg, pop_left_next;

    // result register
    logic                 out_valid_reg, out_valid_next;
    logic [ST_W-1:0]      status_reg;
    logic [BYTE_W-1:0]    data_out_reg;
    logic [PLEN_W-1:0]    plen_reg;
    logic                 last_reg;
    logic [FS_W-1:0]      fs_reg;
    logic                 empty_reg;

    size_t                free_ring;
    logic [FS_W-1:0]      fs_now;
    logic [BYTE_W-1:0]    hdr_byte;
    logic [BYTE_W-1:0]    len_word;
    logic [PLEN_W-1:0]    pop_len_dec;

    // free ring bytes and free payload space
    always_comb
    begin
        if (tail_reg >= head_reg)
        begin
            free_ring = ring_size_reg - {1'b0, tail_reg} + {1'b0, head_reg} - SIZE_W'(1);
        end
        else
        begin
            free_ring = {1'b0, head_reg} - {1'b0, tail_reg} - SIZE_W'(1);
        end
        if (32'(free_ring) > HEADER_BYTES)
        begin
            fs_now = FS_W'(free_ring - SIZE_W'(HEADER_BYTES));
        end
        else
        begin
            fs_now = '0;
        end
    end

    // header byte to store and payload length read from a stored header
    always_comb
    begin
        len_word    = len_reg + BYTE_W'(HEADER_BYTES);
        hdr_byte    = (hdr_cnt_reg == '0) ? len_word : '0;
        pop_len_dec = PLEN_W'(rd_data_reg - BYTE_W'(HEADER_BYTES));
        if (32'(pop_len_dec) > MAX_MSG_LEN - 1)
        begin
            pop_len_dec = PLEN_W'(MAX_MSG_LEN - 1);
        end
    end

    // status to the controller
    always_comb
    begin
        stat.qvalid    = qvalid_reg;
        stat.action    = act_reg;
        stat.start     = start_reg;
        stat.len_bad   = (len_reg == '0) || (32'(len_reg) >= MAX_MSG_LEN);
        stat.len_fits  = (32'(len_reg) + HEADER_BYTES) <= 32'(free_ring);
        stat.left_zero = (left_reg == '0);
        stat.dropping  = drop_reg;
        stat.empty     = (head_reg == tail_reg);
        stat.hdr_last  = (hdr_cnt_reg == HDR_CNT_W'(HEADER_BYTES - 1));
        stat.pop_zero  = (pop_len_reg == '0);
        stat.pop_last  = (pop_left_reg == PLEN_W'(1));
        stat.out_free  = !out_valid_reg || out_ready;
    end

    // memory port control
    always_comb
    begin
        mem_we    = cmd.hdr_wr || cmd.dat_wr;
        mem_waddr = wpos_reg;
        mem_wdata = cmd.hdr_wr ? hdr_byte : data_reg;
        mem_re    = cmd.rd_head || cmd.pop_rd;
        mem_raddr = cmd.rd_head ? head_reg : rd_ptr_reg;
    end

    // ring memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ring_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= ring_mem[mem_raddr];
        end
    end

    // queue state next values
    always_comb
    begin
        ring_size_next = ring_size_reg;
        qvalid_next    = qvalid_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        wpos_next      = wpos_reg;
        left_next      = left_reg;
        drop_next      = drop_reg;
        hdr_cnt_next   = hdr_cnt_reg;
        rd_ptr_next    = rd_ptr_reg;
        pop_len_next   = pop_len_reg;
        pop_left_next  = pop_left_reg;

        // push start accepted
        if (cmd.push_start)
        begin
            wpos_next    = tail_reg;
            hdr_cnt_next = '0;
            left_next    = PLEN_W'(len_reg);
            drop_next    = 1'b0;
        end
        // push start rejected
        if (cmd.drop_start)
        begin
            left_next = '0;
            drop_next = 1'b1;
        end
        // header byte write
        if (cmd.hdr_wr)
        begin
            wpos_next    = adv1(wpos_reg, ring_size_reg);
            hdr_cnt_next = hdr_cnt_reg + HDR_CNT_W'(1);
        end
        // payload byte write, commit on the last one
        if (cmd.dat_wr)
        begin
            wpos_next = adv1(wpos_reg, ring_size_reg);
            left_next = left_reg - PLEN_W'(1);
            if (left_reg == PLEN_W'(1))
            begin
                tail_next = adv1(wpos_reg, ring_size_reg);
            end
        end
        // clear drops any open push
        if (cmd.clear)
        begin
            tail_next = head_reg;
            if (left_reg != '0)
            begin
                left_next = '0;
                drop_next = 1'b1;
            end
        end
        // header decode, payload starts past the header
        if (cmd.pop_hdr)
        begin
            pop_len_next  = pop_len_dec;
            pop_left_next = pop_len_dec;
            rd_ptr_next   = wrap_add(head_reg, SIZE_W'(HEADER_BYTES), ring_size_reg);
        end
        // head moves past the whole message
        if (cmd.pop_end)
        begin
            head_next = wrap_add(rd_ptr_reg, SIZE_W'(pop_len_reg), ring_size_reg);
        end
        if (cmd.pop_rd)
        begin
            rd_ptr_next = adv1(rd_ptr_reg, ring_size_reg);
        end
        if (cmd.emit_byte)
        begin
            pop_left_next = pop_left_reg - PLEN_W'(1);
        end

        // configuration writes
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RING_SIZE:
                begin
                    if (32'(cfg_data) > RING_DEPTH)
                    begin
                        ring_size_next = SIZE_W'(RING_DEPTH);
                    end
                    else if (32'(cfg_data) < RING_MIN)
                    begin
                        ring_size_next = SIZE_W'(RING_MIN);
                    end
                    else
                    begin
                        ring_size_next = SIZE_W'(cfg_data);
                    end
                    head_next = '0;
                    tail_next = '0;
                    wpos_next = '0;
                    left_next = '0;
                    drop_next = 1'b0;
                end
                REG_QUEUE_VALID:
                begin
                    qvalid_next = cfg_data[0];
                end
            endcase
        end
    end

    // queue state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_size_reg <= SIZE_W'(RING_SIZE_RST);
            qvalid_reg    <= 1'b1;
            head_reg      <= '0;
            tail_reg      <= '0;
            wpos_reg      <= '0;
            left_reg      <= '0;
            drop_reg      <= 1'b0;
            hdr_cnt_reg   <= '0;
            rd_ptr_reg    <= '0;
            pop_len_reg   <= '0;
            pop_left_reg  <= '0;
        end
        else
        begin
            ring_size_reg <= ring_size_next;
            qvalid_reg    <= qvalid_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            wpos_reg      <= wpos_next;
            left_reg      <= left_next;
            drop_reg      <= drop_next;
            hdr_cnt_reg   <= hdr_cnt_next;
            rd_ptr_reg    <= rd_ptr_next;
            pop_len_reg   <= pop_len_next;
            pop_left_reg  <= pop_left_next;
        end
    end

    // input item capture on the accepting transaction
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            act_reg   <= action;
            start_reg <= msg_start;
            len_reg   <= msg_length;
            data_reg  <= data_in;
        end
    end

    // result valid
    always_comb
    begin
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, state reflects the finished step
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            status_reg   <= cmd.status;
            data_out_reg <= cmd.emit_byte ? rd_data_reg : '0;
            plen_reg     <= cmd.emit_byte ? pop_len_reg : '0;
            last_reg     <= cmd.emit_byte ? (pop_left_reg == PLEN_W'(1)) : 1'b1;
            fs_reg       <= fs_now;
            empty_reg    <= (head_reg == tail_reg);
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign data_out       = data_out_reg;
    assign payload_length = plen_reg;
    assign last_byte      = last_reg;
    assign free_space     = fs_reg;
    assign queue_empty    = empty_reg;

    // checks
    `LPBQ_ASSERT_IMP(a_head_in_ring, 1'b1, {1'b0, head_reg} < ring_size_reg)
    `LPBQ_ASSERT_IMP(a_tail_in_ring, 1'b1, {1'b0, tail_reg} < ring_size_reg)
    `LPBQ_ASSERT_IMP(a_emit_free, cmd.emit, !out_valid_reg || out_ready)
    `LPBQ_ASSERT_IMP(a_write_open, cmd.dat_wr, left_reg != '0)
    `LPBQ_ASSERT_NXT(a_commit, cmd.dat_wr && (left_reg == PLEN_W'(1)), tail_reg == wpos_reg)

endmodule

/* hdl/length_prefixed_byte_ring_queue.sv */
`timescale 1ns / 1ps
// push: a payload byte runs decode, its payload write and the result step; a start byte first makes four header
// writes (they share the single ring memory write port); a pop reads and decodes the header before its first byte
// sequencing: a new item is taken only once the last result is emitted; popped bytes are read one at a time and
// wait on out_ready, set by the registered read port of the ring memory and the one-read-per-byte sequencer loop
// reset: pointers and flags cleared, ring_size 4096, queue enabled; ring contents undefined,
// no clearing pass
// ----------------------------------------------------------------------------
// length_prefixed_byte_ring_queue
// byte ring queue of length-prefixed messages with push, pop and clear
// ----------------------------------------------------------------------------
module length_prefixed_byte_ring_queue import lpbq_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [ACT_W-1:0]     action,
    input  logic                 msg_start,
    input  logic [LEN_IN_W-1:0]  msg_length,
    input  logic [BYTE_W-1:0]    data_in,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [ST_W-1:0]      status,
    output logic [BYTE_W-1:0]    data_out,
    output logic [PLEN_W-1:0]    payload_length,
    output logic                 last_byte,
    output logic [FS_W-1:0]      free_space,
    output logic                 queue_empty
);

    cmd_t  cmd;
    stat_t stat;

    // sequencer
    lpbq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // ring memory and pointers
    lpbq_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .action         (action),
        .msg_start      (msg_start),
        .msg_length     (msg_length),
        .data_in        (data_in),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .data_out       (data_out),
        .payload_length (payload_length),
        .last_byte      (last_byte),
        .free_space     (free_space),
        .queue_empty    (queue_empty)
    );

endmodule
